// ===== hdl/sbon_pkg.sv =====
// Shared types and codes for the shared bus ownership negotiator.
package sbon_pkg;

    // Command kinds carried by an input request.
    localparam logic [2:0] KIND_REGISTER   = 3'd0;
    localparam logic [2:0] KIND_UNREGISTER = 3'd1;
    localparam logic [2:0] KIND_REQUEST    = 3'd2;
    localparam logic [2:0] KIND_RELEASE    = 3'd3;
    localparam logic [2:0] KIND_TICK       = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;
    localparam logic [1:0] ST_BUSY    = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MODE            = 2'd0;
    localparam logic [1:0] CFG_DEVICE_LIMIT    = 2'd1;
    localparam logic [1:0] CFG_REQUEST_TIMEOUT = 2'd2;
    localparam logic [1:0] CFG_RELEASE_TIMEOUT = 2'd3;

    localparam int CFG_DATA_W = 16;
    localparam int MASK_W     = 8;

    typedef struct packed {
        logic [2:0]        kind;
        logic [MASK_W-1:0] slot_sel;
        logic              peer_line;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        logic [MASK_W-1:0] assigned_mask;
        logic              owner_line;
        logic [MASK_W-1:0] requesters;
    } t_out_item;

    typedef struct packed {
        logic        mode;
        logic [3:0]  device_limit;
        logic [15:0] request_timeout;
        logic [15:0] release_timeout;
    } t_cfg;

endpackage

// ===== hdl/shared_bus_ownership_negotiator.sv =====
// Top level of the shared bus ownership negotiator.
//
//  Channel  | Signals                                    | Content
//  ---------+--------------------------------------------+-----------------------------
//  input    | i_in_valid, o_in_ready, i_in_data          | command or tick request
//  output   | o_out_valid, i_out_ready, o_out_data       | status and slot masks
//  config   | i_cfg_valid, o_cfg_ready, i_cfg_index/data | register write
//
// One request is taken per cycle while the input is not stalled; each is held in the input
// register, and its result, if any, is then registered in the output register.
// The slot-mask and handshake update is combinational logic between the two registers.
// Reset is synchronous and active low; it clears all slots and the handshake state.
// A held result stalls the input only once the input register is also full.
module shared_bus_ownership_negotiator
    import sbon_pkg::*;
#(
    parameter int SLOT_COUNT = 8,
    parameter int TIMER_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    t_cfg      cfg;
    logic      fire;
    logic      emit;
    t_out_item result;

    assign fire        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || fire;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    sbon_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    sbon_step #(
        .SLOT_COUNT (SLOT_COUNT),
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_emit   (emit),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_data;
        end
        if (emit) begin
            r_out_item <= result;
        end
    end

endmodule

// ===== hdl/sbon_cfg.sv =====
// Configuration register file of the negotiator.
module sbon_cfg
    import sbon_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MODE:            n_cfg.mode            = i_cfg_data[0];
                CFG_DEVICE_LIMIT:    n_cfg.device_limit    = i_cfg_data[3:0];
                CFG_REQUEST_TIMEOUT: n_cfg.request_timeout = i_cfg_data[15:0];
                CFG_RELEASE_TIMEOUT: n_cfg.release_timeout = i_cfg_data[15:0];
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode            <= 1'b0;
            r_cfg.device_limit    <= 4'd1;
            r_cfg.request_timeout <= 16'd500;
            r_cfg.release_timeout <= 16'd500;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== hdl/sbon_step.sv =====
// Slot masks, handshake state and the combinational command update.
module sbon_step
    import sbon_pkg::*;
#(
    parameter int SLOT_COUNT = 8,
    parameter int TIMER_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output logic      o_emit,
    output t_out_item o_result
);

    localparam int SLOT_W = (SLOT_COUNT < MASK_W) ? SLOT_COUNT : MASK_W;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_CLAIM = 3'b010,
        PH_YIELD = 3'b100
    } t_phase;

    logic [SLOT_W-1:0]     r_registered, n_registered;
    logic [MASK_W-1:0]     r_requesting, n_requesting;
    logic                  r_drive, n_drive;
    t_phase                r_phase, n_phase;
    logic [TIMER_BITS-1:0] r_countdown, n_countdown;

    logic [SLOT_W-1:0]     free_slots;
    logic [SLOT_W-1:0]     grant;
    logic [TIMER_BITS-1:0] cd_dec;
    logic                  emit;
    logic [1:0]            status;
    logic [MASK_W-1:0]     assigned;

    // Saturate a 16-bit timeout to the counter width; zero counts as one tick.
    function automatic logic [TIMER_BITS-1:0] load_timer(input logic [15:0] t);
        logic [TIMER_BITS-1:0] v;
        v = ((32'(t) >> TIMER_BITS) != 32'd0) ? '1 : TIMER_BITS'(t);
        if (v == '0) begin
            v = TIMER_BITS'(1);
        end
        return v;
    endfunction

    always_comb begin
        for (int i = 0; i < SLOT_W; i++) begin
            free_slots[i] = !r_registered[i] && (4'(i) < i_cfg.device_limit);
        end
    end

    // Isolate the lowest free slot.
    assign grant  = free_slots & (~free_slots + SLOT_W'(1));
    assign cd_dec = (r_countdown != '0) ? r_countdown - TIMER_BITS'(1) : '0;

    always_comb begin
        n_registered = r_registered;
        n_requesting = r_requesting;
        n_drive      = r_drive;
        n_phase      = r_phase;
        n_countdown  = r_countdown;
        emit         = 1'b0;
        status       = ST_OK;
        assigned     = '0;

        case (i_item.kind)
            KIND_TICK: begin
                if (r_phase != PH_IDLE) begin
                    if (i_item.peer_line == r_drive) begin
                        n_phase     = PH_IDLE;
                        n_countdown = '0;
                        emit        = 1'b1;
                    end else if (cd_dec == '0) begin
                        n_phase     = PH_IDLE;
                        n_countdown = '0;
                        emit        = 1'b1;
                        status      = ST_TIMEOUT;
                    end else begin
                        n_countdown = cd_dec;
                    end
                end
            end
            KIND_REGISTER, KIND_UNREGISTER, KIND_REQUEST, KIND_RELEASE: begin
                emit = 1'b1;
                if (r_phase != PH_IDLE) begin
                    status = ST_BUSY;
                end else if (i_item.kind == KIND_REGISTER) begin
                    n_registered = r_registered | grant;
                    n_requesting = r_requesting | MASK_W'(grant);
                    assigned     = MASK_W'(grant);
                end else if (i_item.kind == KIND_UNREGISTER) begin
                    n_registered = r_registered & ~i_item.slot_sel[SLOT_W-1:0];
                end else if ((i_item.slot_sel & MASK_W'(r_registered)) == '0) begin
                    status = ST_INVALID;
                end else if (i_item.kind == KIND_REQUEST) begin
                    n_requesting = r_requesting | i_item.slot_sel;
                    // The first requester claims the bus; mock mode answers at once.
                    if (r_requesting == '0 && !i_cfg.mode) begin
                        emit        = 1'b0;
                        n_drive     = 1'b0;
                        n_phase     = PH_CLAIM;
                        n_countdown = load_timer(i_cfg.request_timeout);
                    end
                end else if (r_requesting == i_item.slot_sel) begin
                    n_requesting = '0;
                    if (!i_cfg.mode) begin
                        emit        = 1'b0;
                        n_drive     = 1'b1;
                        n_phase     = PH_YIELD;
                        n_countdown = load_timer(i_cfg.release_timeout);
                    end
                end else begin
                    n_requesting = r_requesting & ~i_item.slot_sel;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    assign o_emit                 = i_fire && emit;
    assign o_result.status        = status;
    assign o_result.assigned_mask = assigned;
    assign o_result.owner_line    = r_drive;
    assign o_result.requesters    = n_requesting;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_registered <= '0;
            r_requesting <= '0;
            r_drive      <= 1'b0;
            r_phase      <= PH_IDLE;
            r_countdown  <= '0;
        end else if (i_fire) begin
            r_registered <= n_registered;
            r_requesting <= n_requesting;
            r_drive      <= n_drive;
            r_phase      <= n_phase;
            r_countdown  <= n_countdown;
        end
    end

endmodule

// ===== hdl/sbon_checker.sv =====
// Port-level checks for the negotiator and their binding to the top level.
module sbon_checker
    import sbon_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // Reset empties the result register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // The input side only stalls behind a result that is held.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without a held result");

    // A granted slot is a single bit, answered ok, and already requesting.
    a_grant_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.assigned_mask != '0 |->
            $onehot(o_out_data.assigned_mask) && o_out_data.status == ST_OK &&
            (o_out_data.requesters & o_out_data.assigned_mask) == o_out_data.assigned_mask)
        else $error("malformed slot grant");

endmodule

bind shared_bus_ownership_negotiator sbon_checker u_sbon_checker (.*);
